FILE: rtl/core/i2csbh_pkg.sv
// package: shared constants and control types for the i2c slave byte handler
package i2csbh_pkg;

    localparam int unsigned CMD_W     = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned EVENT_W   = 3;
    localparam int unsigned FILL_W    = 6;
    localparam int unsigned FILL_MAX  = 63;
    localparam int unsigned IN_DATA_W = 24;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_BUS_EVENT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_TX   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_RX    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_RX   = 2'd3;

    localparam logic [BYTE_W-1:0] ST_OWN_SLA_W      = 8'h60;
    localparam logic [BYTE_W-1:0] ST_ARB_LOST_SLA_W = 8'h68;
    localparam logic [BYTE_W-1:0] ST_GEN_CALL       = 8'h70;
    localparam logic [BYTE_W-1:0] ST_ARB_LOST_GC    = 8'h78;
    localparam logic [BYTE_W-1:0] ST_DATA_ACK       = 8'h80;
    localparam logic [BYTE_W-1:0] ST_DATA_NAK       = 8'h88;
    localparam logic [BYTE_W-1:0] ST_GC_DATA_ACK    = 8'h90;
    localparam logic [BYTE_W-1:0] ST_GC_DATA_NAK    = 8'h98;
    localparam logic [BYTE_W-1:0] ST_STOP_RESTART   = 8'hA0;
    localparam logic [BYTE_W-1:0] ST_OWN_SLA_R      = 8'hA8;
    localparam logic [BYTE_W-1:0] ST_ARB_LOST_SLA_R = 8'hB0;
    localparam logic [BYTE_W-1:0] ST_TX_DATA_ACK    = 8'hB8;
    localparam logic [BYTE_W-1:0] ST_TX_DATA_NAK    = 8'hC0;
    localparam logic [BYTE_W-1:0] ST_TX_LAST_ACK    = 8'hC8;

    localparam logic [EVENT_W-1:0] EV_OK        = 3'd0;
    localparam logic [EVENT_W-1:0] EV_RX_BYTE   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_TX_BYTE   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SEND_END  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_RECV_END  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_START_STOP = 3'd5;

    localparam logic [BYTE_W-1:0] FILLER_BYTE = 8'h99;

    typedef struct packed {
        logic load_in;
        logic exec;
    } t_dp_cmd;

endpackage

FILE: rtl/core/i2csbh_ctrl.sv
// controller: item sequencing and result register handshake
module i2csbh_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output i2csbh_pkg::t_dp_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic exec;

    assign o_s_tready = (r_state == ST_IDLE);
    assign exec = (r_state == ST_EXEC) && (!r_out_valid || i_m_tready);
    assign o_cmd.load_in = i_s_tvalid && o_s_tready;
    assign o_cmd.exec = exec;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (exec) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/core/i2csbh_dp.sv
// datapath: ring pointers, ring memories, status rules and result register
module i2csbh_dp #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  i2csbh_pkg::t_dp_cmd                 i_cmd,
    input  logic [i2csbh_pkg::CMD_W-1:0]        i_command,
    input  logic [i2csbh_pkg::IN_DATA_W-1:0]    i_in_data,
    output logic [i2csbh_pkg::OUT_DATA_W-1:0]   o_out_data
);

    localparam int unsigned PW = $clog2(RING_DEPTH);

    logic [i2csbh_pkg::BYTE_W-1:0] r_rx_mem [RING_DEPTH];
    logic [i2csbh_pkg::BYTE_W-1:0] r_tx_mem [RING_DEPTH];
    logic [i2csbh_pkg::BYTE_W-1:0] r_rx_rd;
    logic [i2csbh_pkg::BYTE_W-1:0] r_tx_rd;

    logic [PW-1:0] r_rx_head, r_rx_tail, r_tx_head, r_tx_tail;
    logic [PW-1:0] n_rx_head, n_rx_tail, n_tx_head, n_tx_tail;

    logic [i2csbh_pkg::CMD_W-1:0]  r_command;
    logic [i2csbh_pkg::BYTE_W-1:0] r_code;
    logic [i2csbh_pkg::BYTE_W-1:0] r_bus_byte;
    logic [i2csbh_pkg::BYTE_W-1:0] r_app_byte;

    logic                            ack, restart, svalid, adone;
    logic [i2csbh_pkg::BYTE_W-1:0]  sbyte, adata;
    logic [i2csbh_pkg::EVENT_W-1:0] ev;
    logic                            rx_we, tx_we;
    logic                            rx_full, tx_full, rx_empty, tx_empty;
    logic [i2csbh_pkg::OUT_DATA_W-1:0] r_out;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [i2csbh_pkg::FILL_W-1:0] fill_of(
        input logic [PW-1:0] head,
        input logic [PW-1:0] tail
    );
        logic [PW:0] d;
        if (tail >= head) begin
            d = {1'b0, tail} - {1'b0, head};
        end else begin
            d = {1'b0, tail} + (PW+1)'(RING_DEPTH) - {1'b0, head};
        end
        if (32'(d) > 32'(i2csbh_pkg::FILL_MAX)) begin
            return i2csbh_pkg::FILL_W'(i2csbh_pkg::FILL_MAX);
        end
        return i2csbh_pkg::FILL_W'(d);
    endfunction

    assign rx_full  = (r_rx_head == ptr_next(r_rx_tail));
    assign tx_full  = (r_tx_head == ptr_next(r_tx_tail));
    assign rx_empty = (r_rx_head == r_rx_tail);
    assign tx_empty = (r_tx_head == r_tx_tail);

    always_comb begin
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_tx_head = r_tx_head;
        n_tx_tail = r_tx_tail;
        ack       = 1'b0;
        restart   = 1'b0;
        svalid    = 1'b0;
        sbyte     = '0;
        ev        = i2csbh_pkg::EV_OK;
        adata     = '0;
        adone     = 1'b0;
        rx_we     = 1'b0;
        tx_we     = 1'b0;
        unique case (r_command)
            i2csbh_pkg::CMD_BUS_EVENT: begin
                ack = 1'b1;
                unique case (r_code)
                    i2csbh_pkg::ST_ARB_LOST_SLA_W, i2csbh_pkg::ST_ARB_LOST_GC: begin
                        restart = 1'b1;
                    end
                    i2csbh_pkg::ST_DATA_ACK: begin
                        ev = i2csbh_pkg::EV_RX_BYTE;
                        if (!rx_full) begin
                            rx_we     = 1'b1;
                            n_rx_tail = ptr_next(r_rx_tail);
                        end
                        ack = (r_rx_head != ptr_next(n_rx_tail));
                    end
                    i2csbh_pkg::ST_DATA_NAK, i2csbh_pkg::ST_GC_DATA_NAK: begin
                        ev = i2csbh_pkg::EV_RECV_END;
                    end
                    i2csbh_pkg::ST_GC_DATA_ACK: begin
                        ack = 1'b0;
                        if (!rx_full) begin
                            rx_we     = 1'b1;
                            n_rx_tail = ptr_next(r_rx_tail);
                            ev        = i2csbh_pkg::EV_RX_BYTE;
                        end
                    end
                    i2csbh_pkg::ST_OWN_SLA_R, i2csbh_pkg::ST_TX_DATA_ACK: begin
                        svalid = 1'b1;
                        if (!tx_empty) begin
                            sbyte     = r_tx_rd;
                            ev        = i2csbh_pkg::EV_TX_BYTE;
                            n_tx_head = ptr_next(r_tx_head);
                        end else begin
                            sbyte = i2csbh_pkg::FILLER_BYTE;
                        end
                    end
                    i2csbh_pkg::ST_ARB_LOST_SLA_R: begin
                        restart = 1'b1;
                        if (!tx_empty) begin
                            svalid    = 1'b1;
                            sbyte     = r_tx_rd;
                            ev        = i2csbh_pkg::EV_TX_BYTE;
                            n_tx_head = ptr_next(r_tx_head);
                        end
                    end
                    i2csbh_pkg::ST_TX_DATA_NAK, i2csbh_pkg::ST_TX_LAST_ACK: begin
                        ev        = i2csbh_pkg::EV_SEND_END;
                        n_tx_head = r_tx_tail;
                    end
                    i2csbh_pkg::ST_STOP_RESTART: begin
                        ev = i2csbh_pkg::EV_START_STOP;
                    end
                    default: begin
                    end
                endcase
            end
            i2csbh_pkg::CMD_PUSH_TX: begin
                if (!tx_full) begin
                    tx_we     = 1'b1;
                    n_tx_tail = ptr_next(r_tx_tail);
                    adone     = 1'b1;
                end
            end
            i2csbh_pkg::CMD_POP_RX, i2csbh_pkg::CMD_PEEK_RX: begin
                if (!rx_empty) begin
                    adata = r_rx_rd;
                    adone = 1'b1;
                    if (r_command == i2csbh_pkg::CMD_POP_RX) begin
                        n_rx_head = ptr_next(r_rx_head);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && rx_we) begin
            r_rx_mem[r_rx_tail] <= r_bus_byte;
        end
        if (i_cmd.exec && tx_we) begin
            r_tx_mem[r_tx_tail] <= r_app_byte;
        end
        r_rx_rd <= r_rx_mem[r_rx_head];
        r_tx_rd <= r_tx_mem[r_tx_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
        end else if (i_cmd.exec) begin
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_command  <= i_command;
            r_code     <= i_in_data[7:0];
            r_bus_byte <= i_in_data[15:8];
            r_app_byte <= i_in_data[23:16];
        end
        if (i_cmd.exec) begin
            r_out <= {5'd0,
                      fill_of(n_tx_head, n_tx_tail),
                      fill_of(n_rx_head, n_rx_tail),
                      adone, adata, ev, sbyte, svalid, restart, ack};
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: rtl/core/i2c_slave_byte_handler_with_fifos_top.sv
// top level: i2c slave byte handler with receive and transmit rings
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser: command; tdata: status, bus, app bytes
// m_axis    out  tvalid/tready          tdata: result fields
//
// each item is accepted, then executed against the registered ring reads
// one item is in work at a time; the next is taken once the current one executes
// a finished result waits in the output register while the next item is taken
// a stalled output holds the following item in its execute cycle
// reset clears pointers and control only; ring contents need no clearing
module i2c_slave_byte_handler_with_fifos_top #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] command
    input  logic [i2csbh_pkg::CMD_W-1:0]        s_axis_tuser,
    // [7:0] status_code, [15:8] bus_byte, [23:16] app_byte
    input  logic [i2csbh_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] ack_next, [1] restart_master, [2] send_valid, [10:3] send_byte,
    // [13:11] event_res, [21:14] app_data, [22] app_done, [28:23] rx_fill,
    // [34:29] tx_fill, [39:35] zero
    output logic [i2csbh_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    i2csbh_pkg::t_dp_cmd dp_cmd;

    i2csbh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (dp_cmd)
    );

    i2csbh_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_command  (s_axis_tuser),
        .i_in_data  (s_axis_tdata),
        .o_out_data (m_axis_tdata)
    );

endmodule

FILE: tb/tb_top.sv
// testbench for the i2c slave byte handler: ring predictor, directed and random bus and app traffic
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RING_DEPTH  = 64;
    localparam int unsigned ITEM_TARGET = 1050;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [4:0]                      pad;
        logic [i2csbh_pkg::FILL_W-1:0]   tx_fill;
        logic [i2csbh_pkg::FILL_W-1:0]   rx_fill;
        logic                            app_done;
        logic [i2csbh_pkg::BYTE_W-1:0]   app_data;
        logic [i2csbh_pkg::EVENT_W-1:0]  event_res;
        logic [i2csbh_pkg::BYTE_W-1:0]   send_byte;
        logic                            send_valid;
        logic                            restart_master;
        logic                            ack_next;
    } t_reply;

    class i2c_ring_tracker;
        logic [i2csbh_pkg::BYTE_W-1:0] rx_ring [RING_DEPTH];
        logic [i2csbh_pkg::BYTE_W-1:0] tx_ring [RING_DEPTH];
        logic [i2csbh_pkg::FILL_W-1:0] rx_head, rx_tail, tx_head, tx_tail;
        t_reply                        pending_replies [$];
        int unsigned                   failures;

        function new();
            rx_head = '0;
            rx_tail = '0;
            tx_head = '0;
            tx_tail = '0;
            failures = 0;
        endfunction

        function bit rx_full();
            return rx_head == i2csbh_pkg::FILL_W'(rx_tail + 1'b1);
        endfunction

        function bit rx_put(input logic [i2csbh_pkg::BYTE_W-1:0] b);
            if (rx_full())
                return 1'b0;
            rx_ring[rx_tail] = b;
            rx_tail = rx_tail + 1'b1;
            return 1'b1;
        endfunction

        function bit tx_take(output logic [i2csbh_pkg::BYTE_W-1:0] b);
            b = '0;
            if (tx_head == tx_tail)
                return 1'b0;
            b = tx_ring[tx_head];
            tx_head = tx_head + 1'b1;
            return 1'b1;
        endfunction

        function void take_item(input logic [i2csbh_pkg::CMD_W-1:0] cmd,
                                input logic [i2csbh_pkg::BYTE_W-1:0] code,
                                input logic [i2csbh_pkg::BYTE_W-1:0] bus_b,
                                input logic [i2csbh_pkg::BYTE_W-1:0] app_b);
            t_reply                        r;
            logic [i2csbh_pkg::BYTE_W-1:0] b;
            r = '0;
            case (cmd)
                i2csbh_pkg::CMD_BUS_EVENT: begin
                    r.ack_next = 1'b1;
                    case (code)
                        i2csbh_pkg::ST_ARB_LOST_SLA_W,
                        i2csbh_pkg::ST_ARB_LOST_GC: r.restart_master = 1'b1;
                        i2csbh_pkg::ST_DATA_ACK: begin
                            void'(rx_put(bus_b));
                            r.event_res = i2csbh_pkg::EV_RX_BYTE;
                            r.ack_next = !rx_full();
                        end
                        i2csbh_pkg::ST_DATA_NAK,
                        i2csbh_pkg::ST_GC_DATA_NAK: r.event_res = i2csbh_pkg::EV_RECV_END;
                        i2csbh_pkg::ST_GC_DATA_ACK: begin
                            r.event_res = rx_put(bus_b) ? i2csbh_pkg::EV_RX_BYTE
                                                        : i2csbh_pkg::EV_OK;
                            r.ack_next = 1'b0;
                        end
                        i2csbh_pkg::ST_OWN_SLA_R, i2csbh_pkg::ST_TX_DATA_ACK: begin
                            r.send_valid = 1'b1;
                            if (tx_take(b)) begin
                                r.send_byte = b;
                                r.event_res = i2csbh_pkg::EV_TX_BYTE;
                            end else begin
                                r.send_byte = i2csbh_pkg::FILLER_BYTE;
                            end
                        end
                        i2csbh_pkg::ST_ARB_LOST_SLA_R: begin
                            r.restart_master = 1'b1;
                            if (tx_take(b)) begin
                                r.send_valid = 1'b1;
                                r.send_byte = b;
                                r.event_res = i2csbh_pkg::EV_TX_BYTE;
                            end
                        end
                        i2csbh_pkg::ST_TX_DATA_NAK, i2csbh_pkg::ST_TX_LAST_ACK: begin
                            r.event_res = i2csbh_pkg::EV_SEND_END;
                            tx_head = tx_tail;
                        end
                        i2csbh_pkg::ST_STOP_RESTART: r.event_res = i2csbh_pkg::EV_START_STOP;
                        default: ;
                    endcase
                end
                i2csbh_pkg::CMD_PUSH_TX: begin
                    if (tx_head != i2csbh_pkg::FILL_W'(tx_tail + 1'b1)) begin
                        tx_ring[tx_tail] = app_b;
                        tx_tail = tx_tail + 1'b1;
                        r.app_done = 1'b1;
                    end
                end
                default: begin
                    if (rx_head != rx_tail) begin
                        r.app_data = rx_ring[rx_head];
                        r.app_done = 1'b1;
                        if (cmd == i2csbh_pkg::CMD_POP_RX)
                            rx_head = rx_head + 1'b1;
                    end
                end
            endcase
            r.rx_fill = rx_tail - rx_head;
            r.tx_fill = tx_tail - tx_head;
            pending_replies.push_back(r);
        endfunction

        function void compare(input string name, input logic [7:0] want, input logic [7:0] got);
            if (want !== got) begin
                $error("%s expected %0h actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_reply(input t_reply got);
            t_reply want;
            if (pending_replies.size() == 0) begin
                $error("result transfer with nothing expected: %h", got);
                failures++;
                return;
            end
            want = pending_replies.pop_front();
            compare("ack_next", 8'(want.ack_next), 8'(got.ack_next));
            compare("restart_master", 8'(want.restart_master), 8'(got.restart_master));
            compare("send_valid", 8'(want.send_valid), 8'(got.send_valid));
            compare("send_byte", want.send_byte, got.send_byte);
            compare("event_res", 8'(want.event_res), 8'(got.event_res));
            compare("app_data", want.app_data, got.app_data);
            compare("app_done", 8'(want.app_done), 8'(got.app_done));
            compare("rx_fill", 8'(want.rx_fill), 8'(got.rx_fill));
            compare("tx_fill", 8'(want.tx_fill), 8'(got.tx_fill));
            compare("pad", 8'(want.pad), 8'(got.pad));
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [i2csbh_pkg::CMD_W-1:0]      s_axis_tuser;
    logic [i2csbh_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [i2csbh_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    i2c_ring_tracker tracker;
    int unsigned     items_sent;
    int unsigned     send_gap_max;
    int unsigned     recv_stall_max;
    int unsigned     cycle_count;

    i2c_slave_byte_handler_with_fifos_top #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("i2c_slave_byte_handler_with_fifos_top verification failed");
            $finish;
        end
    end

    // one input transfer; tvalid only drops when a gap is drawn
    task automatic send_item(input logic [i2csbh_pkg::CMD_W-1:0] cmd,
                             input logic [i2csbh_pkg::BYTE_W-1:0] code,
                             input logic [i2csbh_pkg::BYTE_W-1:0] bus_b,
                             input logic [i2csbh_pkg::BYTE_W-1:0] app_b);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {app_b, bus_b, code};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_item(cmd, code, bus_b, app_b);
        items_sent++;
    endtask

    task automatic bus_event(input logic [i2csbh_pkg::BYTE_W-1:0] code,
                             input logic [i2csbh_pkg::BYTE_W-1:0] bus_b);
        send_item(i2csbh_pkg::CMD_BUS_EVENT, code, bus_b, i2csbh_pkg::BYTE_W'($urandom));
    endtask

    task automatic app_item(input logic [i2csbh_pkg::CMD_W-1:0] cmd,
                            input logic [i2csbh_pkg::BYTE_W-1:0] app_b);
        send_item(cmd, i2csbh_pkg::BYTE_W'($urandom), i2csbh_pkg::BYTE_W'($urandom), app_b);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        bus_event(i2csbh_pkg::ST_OWN_SLA_W, 8'h00);
        bus_event(i2csbh_pkg::ST_ARB_LOST_SLA_W, 8'hFF);
        bus_event(i2csbh_pkg::ST_GEN_CALL, 8'h00);
        bus_event(i2csbh_pkg::ST_ARB_LOST_GC, 8'hFF);
        bus_event(i2csbh_pkg::ST_STOP_RESTART, 8'h00);
        bus_event(i2csbh_pkg::ST_DATA_NAK, 8'h00);
        bus_event(i2csbh_pkg::ST_GC_DATA_NAK, 8'hFF);
        bus_event(8'hF8, 8'h00);
        bus_event(8'h61, 8'hFF);
        bus_event(8'hFF, 8'hFF);
        bus_event(8'h00, 8'h00);
        app_item(i2csbh_pkg::CMD_POP_RX, 8'h00);
        app_item(i2csbh_pkg::CMD_PEEK_RX, 8'hFF);
        bus_event(i2csbh_pkg::ST_OWN_SLA_R, 8'h00);
        bus_event(i2csbh_pkg::ST_ARB_LOST_SLA_R, 8'h00);
        app_item(i2csbh_pkg::CMD_PUSH_TX, 8'hFF);
        app_item(i2csbh_pkg::CMD_PUSH_TX, 8'h00);
        bus_event(i2csbh_pkg::ST_TX_DATA_ACK, 8'h00);
        bus_event(i2csbh_pkg::ST_ARB_LOST_SLA_R, 8'h00);
        bus_event(i2csbh_pkg::ST_DATA_ACK, 8'hFF);
        bus_event(i2csbh_pkg::ST_GC_DATA_ACK, 8'h00);
        app_item(i2csbh_pkg::CMD_PEEK_RX, 8'h00);
        app_item(i2csbh_pkg::CMD_POP_RX, 8'h00);
        app_item(i2csbh_pkg::CMD_POP_RX, 8'h00);
        app_item(i2csbh_pkg::CMD_PUSH_TX, 8'h5A);
        bus_event(i2csbh_pkg::ST_TX_DATA_NAK, 8'h00);
        bus_event(i2csbh_pkg::ST_TX_LAST_ACK, 8'h00);
    endtask

    task automatic run_random();
        logic [i2csbh_pkg::BYTE_W-1:0] known_codes [15];
        int unsigned                   kind;
        int unsigned                   len;
        bit                            gen_call;
        bit                            drained_once;
        known_codes = '{i2csbh_pkg::ST_OWN_SLA_W, i2csbh_pkg::ST_ARB_LOST_SLA_W,
                        i2csbh_pkg::ST_GEN_CALL, i2csbh_pkg::ST_ARB_LOST_GC,
                        i2csbh_pkg::ST_DATA_ACK, i2csbh_pkg::ST_DATA_NAK,
                        i2csbh_pkg::ST_GC_DATA_ACK, i2csbh_pkg::ST_GC_DATA_NAK,
                        i2csbh_pkg::ST_STOP_RESTART, i2csbh_pkg::ST_OWN_SLA_R,
                        i2csbh_pkg::ST_ARB_LOST_SLA_R, i2csbh_pkg::ST_TX_DATA_ACK,
                        i2csbh_pkg::ST_TX_DATA_NAK, i2csbh_pkg::ST_TX_LAST_ACK, 8'hF8};
        drained_once = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    // master writes to us
                    gen_call = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 3))
                        0: bus_event(i2csbh_pkg::ST_OWN_SLA_W, i2csbh_pkg::BYTE_W'($urandom));
                        1: bus_event(i2csbh_pkg::ST_ARB_LOST_SLA_W,
                                     i2csbh_pkg::BYTE_W'($urandom));
                        2: bus_event(i2csbh_pkg::ST_GEN_CALL, i2csbh_pkg::BYTE_W'($urandom));
                        default: bus_event(i2csbh_pkg::ST_ARB_LOST_GC,
                                           i2csbh_pkg::BYTE_W'($urandom));
                    endcase
                    repeat (len)
                        bus_event(gen_call ? i2csbh_pkg::ST_GC_DATA_ACK : i2csbh_pkg::ST_DATA_ACK,
                                  i2csbh_pkg::BYTE_W'($urandom));
                    case ($urandom_range(0, 2))
                        0: bus_event(gen_call ? i2csbh_pkg::ST_GC_DATA_NAK
                                              : i2csbh_pkg::ST_DATA_NAK,
                                     i2csbh_pkg::BYTE_W'($urandom));
                        default: bus_event(i2csbh_pkg::ST_STOP_RESTART,
                                           i2csbh_pkg::BYTE_W'($urandom));
                    endcase
                end
                2, 3: begin
                    // master reads from us
                    bus_event($urandom_range(0, 2) == 0 ? i2csbh_pkg::ST_ARB_LOST_SLA_R
                                                        : i2csbh_pkg::ST_OWN_SLA_R,
                              i2csbh_pkg::BYTE_W'($urandom));
                    repeat (len - 1)
                        bus_event(i2csbh_pkg::ST_TX_DATA_ACK, i2csbh_pkg::BYTE_W'($urandom));
                    bus_event($urandom_range(0, 1) ? i2csbh_pkg::ST_TX_DATA_NAK
                                                   : i2csbh_pkg::ST_TX_LAST_ACK,
                              i2csbh_pkg::BYTE_W'($urandom));
                end
                4, 5: repeat (len)
                    app_item(i2csbh_pkg::CMD_PUSH_TX, i2csbh_pkg::BYTE_W'($urandom));
                6, 7: repeat (len)
                    app_item($urandom_range(0, 3) == 0 ? i2csbh_pkg::CMD_PEEK_RX
                                                       : i2csbh_pkg::CMD_POP_RX,
                             i2csbh_pkg::BYTE_W'($urandom));
                default: begin
                    repeat (len) begin
                        if ($urandom_range(0, 1))
                            send_item(i2csbh_pkg::CMD_BUS_EVENT,
                                      $urandom_range(0, 1)
                                          ? i2csbh_pkg::BYTE_W'($urandom)
                                          : known_codes[4'($urandom_range(0, 14))],
                                      i2csbh_pkg::BYTE_W'($urandom),
                                      i2csbh_pkg::BYTE_W'($urandom));
                        else
                            send_item(i2csbh_pkg::CMD_W'($urandom),
                                      i2csbh_pkg::BYTE_W'($urandom),
                                      i2csbh_pkg::BYTE_W'($urandom),
                                      i2csbh_pkg::BYTE_W'($urandom));
                    end
                end
            endcase
            if ((!drained_once && items_sent > ITEM_TARGET / 2) || $urandom_range(0, 14) == 0) begin
                wait_drained();
                drained_once = 1'b1;
            end
        end
    endtask

    // result side with random stalls, switching between stall and no-stall stretches
    initial begin
        m_axis_tready <= 1'b0;
        recv_stall_max = 10;
        @(posedge i_rst_n);
        forever begin
            int unsigned stall;
            if ($urandom_range(0, 31) == 0)
                recv_stall_max = $urandom_range(0, 1) * 10;
            stall = $urandom_range(0, recv_stall_max);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            tracker.check_reply(t_reply'(m_axis_tdata));
        end
    end

    initial begin
        tracker = new();
        items_sent = 0;
        send_gap_max = 10;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= '0;
        s_axis_tdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_replies.size() == 0) begin
            $display("i2c_slave_byte_handler_with_fifos_top verification clean");
        end else begin
            $display("i2c_slave_byte_handler_with_fifos_top verification failed");
        end
        $finish;
    end

endmodule
